// ===== hw/rtl/spq_pkg.sv =====
// Shared types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_WAIT,
    S_INS_CMP,
    S_INS_PUT,
    S_HOLD
  } state_t;

  // Which logical entry the datapath reads
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_LAST,
    RD_BELOW
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    shift;
    logic    put;
    logic    pop;
    logic    stage_full;
    logic    stage_empty;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic greater;
    logic pos_one;
  } dp_status_t;

endpackage

// ===== hw/rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/spq_datapath.sv =====
// Datapath: circular sorted store, insert pointer, staging and output registers.
`timescale 1ns / 1ps
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::ctrl_cmd_t              cmd,
  input  logic [spq_pkg::VALUE_W-1:0]     value,
  output spq_pkg::dp_status_t             dp_status,
  output logic [spq_pkg::VALUE_W-1:0]     out_value,
  output logic [spq_pkg::STATUS_W-1:0]    status,
  output logic [spq_pkg::COUNT_W-1:0]     count,
  output logic                            is_empty
);

  logic [AW-1:0]                 head;
  logic [CW-1:0]                 entry_count;
  logic [AW-1:0]                 pos;
  logic [spq_pkg::VALUE_W-1:0]   val_hold;
  logic [spq_pkg::VALUE_W-1:0]   stage_value;
  spq_pkg::status_t              stage_status;

  logic [AW-1:0]                 rd_log;
  logic [AW-1:0]                 raddr;
  logic [AW-1:0]                 waddr;
  logic [spq_pkg::VALUE_W-1:0]   wdata;
  logic                          we;
  logic [spq_pkg::VALUE_W-1:0]   rdata;

  // Map a logical slot (0 = smallest) onto the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      spq_pkg::RD_HEAD:  rd_log = '0;
      spq_pkg::RD_LAST:  rd_log = AW'(entry_count - 1'b1);
      spq_pkg::RD_BELOW: rd_log = pos - AW'(2);
      default:           rd_log = '0;
    endcase
  end

  assign raddr = phys(head, rd_log);
  assign waddr = phys(head, pos);
  assign we    = cmd.shift | cmd.put;
  assign wdata = cmd.shift ? rdata : val_hold;

  spq_ram #(
    .WIDTH (spq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dp_status.full    = (entry_count == CW'(DEPTH));
  assign dp_status.empty   = (entry_count == '0);
  assign dp_status.greater = ($signed(rdata) > $signed(val_hold));
  assign dp_status.pos_one = (pos == AW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.put) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.pop) begin
        entry_count <= entry_count - 1'b1;
        head        <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_hold <= value;
      pos      <= AW'(entry_count);
    end else if (cmd.shift) begin
      pos <= pos - 1'b1;
    end

    if (cmd.put) begin
      stage_value  <= '0;
      stage_status <= spq_pkg::ST_OK;
    end else if (cmd.pop) begin
      stage_value  <= rdata;
      stage_status <= spq_pkg::ST_OK;
    end else if (cmd.stage_full) begin
      stage_value  <= '0;
      stage_status <= spq_pkg::ST_FULL;
    end else if (cmd.stage_empty) begin
      stage_value  <= spq_pkg::EMPTY_VALUE;
      stage_status <= spq_pkg::ST_EMPTY;
    end

    if (cmd.load_out) begin
      out_value <= stage_value;
      status    <= stage_status;
      count     <= spq_pkg::COUNT_W'(entry_count);
      is_empty  <= (entry_count == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> entry_count == CW'($past(entry_count) - 1'b1))
    else $error("pop did not drop the count by one");

  a_put_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !dp_status.full)
    else $error("write into a full store");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> pos != '0)
    else $error("shift below the smallest slot");

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Controller: sequences insert shifts, removes and result handoff.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                command,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spq_pkg::dp_status_t dp_status,
  output spq_pkg::ctrl_cmd_t  cmd
);

  spq_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == spq_pkg::S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = spq_pkg::RD_HEAD;

    case (state)
      spq_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (command == spq_pkg::CMD_INSERT) begin
            if (dp_status.full) begin
              cmd.stage_full = 1'b1;
              state_next     = spq_pkg::S_HOLD;
            end else if (dp_status.empty) begin
              state_next = spq_pkg::S_INS_PUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = spq_pkg::RD_LAST;
              state_next = spq_pkg::S_INS_CMP;
            end
          end else begin
            if (dp_status.empty) begin
              cmd.stage_empty = 1'b1;
              state_next      = spq_pkg::S_HOLD;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = spq_pkg::S_REM_WAIT;
            end
          end
        end
      end
      spq_pkg::S_REM_WAIT: begin
        cmd.pop    = 1'b1;
        state_next = spq_pkg::S_HOLD;
      end
      spq_pkg::S_INS_CMP: begin
        // Move the larger entry up one slot and fetch the next one below
        if (dp_status.greater) begin
          cmd.shift = 1'b1;
          if (dp_status.pos_one) begin
            state_next = spq_pkg::S_INS_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_BELOW;
          end
        end else begin
          cmd.put    = 1'b1;
          state_next = spq_pkg::S_HOLD;
        end
      end
      spq_pkg::S_INS_PUT: begin
        cmd.put    = 1'b1;
        state_next = spq_pkg::S_HOLD;
      end
      spq_pkg::S_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before its beat was taken");

  a_hold_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == spq_pkg::S_IDLE && out_valid)
    else $error("result handoff did not return to idle");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift && cmd.put))
    else $error("two writes in one cycle");

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted-array minimum priority queue.
// A remove pops the head into staging; an insert moves each larger entry up one slot and
// writes the new value; both then load the output registers. One item at a time: the next
// input beat is taken only once the result is loaded; the insert cost is set by the
// one-entry-per-cycle shift through the RAM port. A result not taken holds the following
// one. Synchronous active-high reset empties the queue.
`timescale 1ns / 1ps
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [spq_pkg::VALUE_W-1:0]     value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::VALUE_W-1:0]     out_value,
  output logic [spq_pkg::STATUS_W-1:0]    status,
  output logic [spq_pkg::COUNT_W-1:0]     count,
  output logic                            is_empty
);

  spq_pkg::ctrl_cmd_t  cmd;
  spq_pkg::dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .dp_status (dp_status),
    .out_value (out_value),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEF;
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_WAIT  = QDEPTH + 40;

  typedef struct packed {
    logic [spq_pkg::VALUE_W-1:0] value;
    spq_pkg::status_t            status;
    logic [spq_pkg::COUNT_W-1:0] count;
    logic                        is_empty;
  } qresult_t;

  typedef struct packed {
    logic                        cmd;
    logic [spq_pkg::VALUE_W-1:0] val;
    logic                        typed;
    qresult_t                    res;
  } stim_row_t;

  localparam int N_ROWS = 24;
  localparam qresult_t NO_RES = '{value: '0, status: spq_pkg::ST_OK, count: '0, is_empty: 1'b0};

  // Typed rows: after reset, the extremes and the empty case; the rest go through the predictor
  localparam stim_row_t PLAN [N_ROWS] = '{
    '{spq_pkg::CMD_REMOVE, 32'h1234_5678, 1'b1,
      '{spq_pkg::EMPTY_VALUE, spq_pkg::ST_EMPTY, 7'd0, 1'b1}},
    '{spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h0, spq_pkg::ST_OK, 7'd1, 1'b0}},
    '{spq_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, '{32'h0, spq_pkg::ST_OK, 7'd2, 1'b0}},
    '{spq_pkg::CMD_INSERT, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'hFFFF_FFFB, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'h0000_0001, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1,
      '{32'h8000_0000, spq_pkg::ST_OK, 7'd7, 1'b0}},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'hA5A5_A5A5, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h5A5A_5A5A, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'h0000_0005, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1,
      '{32'h7FFF_FFFF, spq_pkg::ST_OK, 7'd0, 1'b1}},
    '{spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1,
      '{spq_pkg::EMPTY_VALUE, spq_pkg::ST_EMPTY, 7'd0, 1'b1}},
    '{spq_pkg::CMD_INSERT, 32'h5555_5555, 1'b0, NO_RES},
    '{spq_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
    '{spq_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, NO_RES}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         command = spq_pkg::CMD_INSERT;
  logic [spq_pkg::VALUE_W-1:0]  value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [spq_pkg::VALUE_W-1:0]  out_value;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::COUNT_W-1:0]  count;
  logic                         is_empty;

  logic signed [spq_pkg::VALUE_W-1:0] held_values[$];
  qresult_t                           pending_results[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_items   = 0;
  int n_inserts = 0;
  int n_full    = 0;
  int n_empty   = 0;
  int n_results = 0;
  int mismatches = 0;
  int unexpected = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .status(status), .count(count), .is_empty(is_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Stable-sorted insert: the new value goes behind every stored value that is not greater.
  task automatic predict_queue(input logic cmd, input logic [spq_pkg::VALUE_W-1:0] val,
                               output qresult_t r);
    int pos;
    r = NO_RES;
    if (cmd == spq_pkg::CMD_INSERT) begin
      n_inserts++;
      if (held_values.size() >= QDEPTH) begin
        r.status = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        pos = held_values.size();
        while (pos > 0 && held_values[pos-1] > $signed(val)) pos--;
        held_values.insert(pos, $signed(val));
      end
    end else begin
      if (held_values.size() == 0) begin
        r.value  = spq_pkg::EMPTY_VALUE;
        r.status = spq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.value = held_values.pop_front();
      end
    end
    r.count    = spq_pkg::COUNT_W'(held_values.size());
    r.is_empty = (held_values.size() == 0);
  endtask

  // Enter and leave at a falling edge; in_valid is touched at most once per edge.
  task automatic issue(input logic cmd, input logic [spq_pkg::VALUE_W-1:0] val,
                       input logic typed, input qresult_t typed_res);
    qresult_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      command  <= 1'($urandom_range(0, 1));
      value    <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    predict_queue(cmd, val, r);
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
    @(negedge clk);
  endtask

  function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
    logic [spq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      4, 5, 6: v = spq_pkg::VALUE_W'($signed($urandom_range(0, 16)) - 8);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      8: v = (held_values.size() > 0) ?
             held_values[$urandom_range(0, held_values.size() - 1)] : $urandom;
      9: v = $urandom & 32'h8000_000F;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic issue_random(input int ins_pct);
    issue(($urandom_range(0, 99) < ins_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE,
          pick_value(), 1'b0, NO_RES);
  endtask

  // Drop valid and hold the sender until every expected beat has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    qresult_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        unexpected++;
        $display("[%0t] result with nothing pending: value=%h status=%0d count=%0d empty=%0b",
                 $realtime, out_value, status, count, is_empty);
      end else begin
        e = pending_results.pop_front();
        if (out_value !== e.value || status !== e.status || count !== e.count ||
            is_empty !== e.is_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: exp value=%h status=%0d count=%0d empty=%0b, %s%h %0d %0d %0b",
                     $realtime, e.value, e.status, e.count, e.is_empty, "got ",
                     out_value, status, count, is_empty);
        end
      end
    end
  end

  initial begin
    int ph;
    int base;
    int mark;
    int seg_len;
    int ins_pct;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      issue(PLAN[i].cmd, PLAN[i].val, PLAN[i].typed, PLAN[i].res);
    end

    for (ph = 0; ph < 4; ph++) begin
      // Hold the sender until the block has returned everything
      wait_results_done();
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      base = n_items;
      // Fill past the top, then drain past the bottom
      mark = n_full;
      while (n_full - mark < 3) issue(spq_pkg::CMD_INSERT, pick_value(), 1'b0, NO_RES);
      mark = n_empty;
      while (n_empty - mark < 3) issue(spq_pkg::CMD_REMOVE, $urandom, 1'b0, NO_RES);
      while (n_items - base < PHASE_ITEMS) begin
        seg_len = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       ins_pct = 92;
          1:       ins_pct = 15;
          default: ins_pct = 55;
        endcase
        repeat (seg_len) issue_random(ins_pct);
      end
    end

    stall_pct = 0;
    wait_results_done();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d items (%0d inserts), %0d refused as full, %0d removes from empty.",
             n_items, n_inserts, n_full, n_empty);
    $display("Checked %0d results: %0d mismatched, %0d unexpected, %0d still pending.",
             n_results, mismatches, unexpected, pending_results.size());
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
